@@ src/as_pkg.sv @@
`timescale 1ns / 1ps

package as_pkg;

  // Width of one element; fixed by the item format.
  localparam int VALUE_BITS = 8;

  // Default number of cells in the sorting chain.
  localparam int DEPTH_DEFAULT = 32;

  // Input item: one element, with the flag that closes the set.
  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic                  last;
  } item_t;

  // Result item: one element in ascending order, with the end-of-set flag.
  typedef struct packed {
    logic [VALUE_BITS-1:0] sorted_value;
    logic                  final_res;
  } result_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic insert;  // place the broadcast value into the sorted chain
    logic drain;   // move every element one cell toward the head
  } cell_ctrl_t;

  // Sequencer states.
  typedef enum logic {
    ST_LOAD,
    ST_EMIT
  } state_t;

endpackage

@@ src/as_cell.sv @@
`timescale 1ns / 1ps

module as_cell (
  input  logic                              clk,
  input  as_pkg::cell_ctrl_t                ctrl,
  input  logic [as_pkg::VALUE_BITS-1:0]     ins_value,
  input  logic [as_pkg::VALUE_BITS-1:0]     prev_value,
  input  logic                              prev_take,
  input  logic [as_pkg::VALUE_BITS-1:0]     next_value,
  input  logic                              occupied,
  output logic [as_pkg::VALUE_BITS-1:0]     held,
  output logic                              take
);

  logic [as_pkg::VALUE_BITS-1:0] held_next;

  // This cell lies at or beyond the insertion point. A strict compare puts a
  // new element behind any equal ones, so equal elements keep arrival order.
  assign take = !occupied || (ins_value < held);

  // On insert, cells past the insertion point take their upstream neighbor,
  // and the cell at the insertion point takes the new element. On drain,
  // every cell takes its downstream neighbor.
  always_comb begin
    held_next = held;
    if (ctrl.insert) begin
      if (take) begin
        held_next = prev_take ? prev_value : ins_value;
      end
    end else if (ctrl.drain) begin
      held_next = next_value;
    end
  end

  always_ff @(posedge clk) begin
    held <= held_next;
  end

endmodule

@@ src/ascending_sorter.sv @@
`timescale 1ns / 1ps

// Channel  Ports                         Handshake                Payload
// -------  ----------------------------  -----------------------  ----------------------
// item     start, busy, item             start & !busy at edge    value, last
// result   strobe, result                strobe, one cycle        sorted_value, final_res
//
// Loading places each accepted element directly into its sorted position in
// the cell chain, which compares it against every cell, so loading never holds
// off the sender; once the chain is full, further elements are dropped. After
// the item carrying last, busy is high while the chain drains toward the head,
// one result per cycle. The next item is accepted in the cycle after the final
// result. Synchronous reset empties the set; the cells themselves are not
// cleared. The receiver cannot stall results.

module ascending_sorter #(
  parameter int DEPTH = as_pkg::DEPTH_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  as_pkg::item_t    item,
  output logic             strobe,
  output as_pkg::result_t  result
);

  localparam int CW = $clog2(DEPTH + 1);

  as_pkg::state_t      state;
  as_pkg::state_t      state_next;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  as_pkg::cell_ctrl_t  ctrl;
  logic                accept;
  logic                room;

  logic [as_pkg::VALUE_BITS-1:0] held [DEPTH];
  logic [DEPTH-1:0]              take;

  assign accept = start && (state == as_pkg::ST_LOAD);
  assign room   = (count < CW'(DEPTH));

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      as_pkg::ST_LOAD: begin
        if (accept && item.last) begin
          state_next = as_pkg::ST_EMIT;
        end
      end
      as_pkg::ST_EMIT: begin
        if (count == CW'(1)) begin
          state_next = as_pkg::ST_LOAD;
        end
      end
      default: begin
        state_next = as_pkg::ST_LOAD;
      end
    endcase
  end

  // Outputs and cell commands.
  always_comb begin
    busy        = 1'b0;
    strobe      = 1'b0;
    ctrl.insert = 1'b0;
    ctrl.drain  = 1'b0;
    case (state)
      as_pkg::ST_LOAD: begin
        ctrl.insert = accept && room;
      end
      as_pkg::ST_EMIT: begin
        busy       = 1'b1;
        strobe     = 1'b1;
        ctrl.drain = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  assign result.sorted_value = held[0];
  assign result.final_res    = (count == CW'(1));

  // Fill count: grows on each stored element, shrinks on each result.
  always_comb begin
    count_next = count;
    if (ctrl.insert) begin
      count_next = count + CW'(1);
    end else if (ctrl.drain) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= as_pkg::ST_LOAD;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  // The chain: cell 0 holds the smallest element.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [as_pkg::VALUE_BITS-1:0] prev_value;
    logic                          prev_take;
    logic [as_pkg::VALUE_BITS-1:0] next_value;

    if (i == 0) begin : g_head
      assign prev_value = item.value;
      assign prev_take  = 1'b0;
    end else begin : g_body
      assign prev_value = held[i-1];
      assign prev_take  = take[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign next_value = held[i];
    end else begin : g_inner
      assign next_value = held[i+1];
    end

    as_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .ins_value  (item.value),
      .prev_value (prev_value),
      .prev_take  (prev_take),
      .next_value (next_value),
      .occupied   (CW'(i) < count),
      .held       (held[i]),
      .take       (take[i])
    );
  end

  // A result never appears from an empty set.
  a_strobe_nonempty: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (count != '0))
    else $error("result issued with an empty set");

  // The final result returns the block to loading.
  a_final_ends: assert property (@(posedge clk) disable iff (rst)
    (strobe && result.final_res) |=> (!busy && (count == '0)))
    else $error("block still busy after the final result");

  // A closing item always starts the drain.
  a_last_starts: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && item.last) |=> (busy && strobe))
    else $error("closing item did not start the output of the set");

  // Output continues without gaps until the final result.
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (strobe && !result.final_res) |=> strobe)
    else $error("gap in the output of a set");

  // Insertion never exceeds the chain length.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    ctrl.insert |-> (count < CW'(DEPTH)))
    else $error("element inserted into a full chain");

endmodule

@@ test/tb_ascending_sorter.sv @@
`timescale 1ns / 1ps

// Tracks the open set as the block should hold it and queues the sorted
// output that each closing item must produce.
class sorted_set_checker;
  int depth;
  logic [as_pkg::VALUE_BITS-1:0] held_values[$];
  as_pkg::result_t expected_results[$];
  int mismatches;
  int results_seen;
  int sets_closed;
  int overflow_sets;
  bit overflowed;

  function new(int depth_cells);
    depth = depth_cells;
  endfunction

  // An accepted item joins the set in sorted position, after any equal value,
  // unless the store is already full. A closing item empties the set.
  function void load_value(as_pkg::item_t it);
    int pos;
    as_pkg::result_t r;
    if (held_values.size() < depth) begin
      pos = held_values.size();
      while (pos > 0 && held_values[pos-1] > it.value) pos--;
      held_values.insert(pos, it.value);
    end else begin
      overflowed = 1'b1;
    end
    if (it.last) begin
      foreach (held_values[k]) begin
        r.sorted_value = held_values[k];
        r.final_res = (k == held_values.size() - 1);
        expected_results.push_back(r);
      end
      held_values.delete();
      sets_closed++;
      if (overflowed) overflow_sets++;
      overflowed = 1'b0;
    end
  endfunction

  // Compares one emitted item with the oldest expectation.
  function void check_result(as_pkg::result_t act);
    as_pkg::result_t exp;
    results_seen++;
    if (expected_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: unexpected result: value %0d final %0b",
                 $time, act.sorted_value, act.final_res);
      return;
    end
    exp = expected_results.pop_front();
    if (act.sorted_value !== exp.sorted_value || act.final_res !== exp.final_res) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: mismatch: expected value %0d final %0b, got value %0d final %0b",
                 $time, exp.sorted_value, exp.final_res, act.sorted_value, act.final_res);
    end
  endfunction
endclass

module tb_ascending_sorter;

  localparam int DEPTH = as_pkg::DEPTH_DEFAULT;
  localparam int ITEMS_PER_PHASE = 133;

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            start = 1'b0;
  logic            busy;
  as_pkg::item_t   item = '0;
  logic            strobe;
  as_pkg::result_t result;

  int items_sent;
  sorted_set_checker sort_model;

  ascending_sorter #(.DEPTH(DEPTH)) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .item   (item),
    .strobe (strobe),
    .result (result)
  );

  // Free-running 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Results are checked before a new item is noted, since any result in the
  // same cycle belongs to an earlier set.
  always @(posedge clk) begin
    if (!rst) begin
      if (strobe) sort_model.check_result(result);
      if (start && !busy) sort_model.load_value(item);
    end
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input logic [as_pkg::VALUE_BITS-1:0] v, input logic l);
    @(negedge clk);
    start <= 1'b1;
    item <= '{value: v, last: l};
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  // With the given percent chance, idles with noise on the item.
  task automatic idle_gap(input int pct);
    int n;
    if ($urandom_range(99) < pct) begin
      n = $urandom_range(4, 1);
      repeat (n) begin
        @(negedge clk);
        start <= 1'b0;
        item <= '{value: as_pkg::VALUE_BITS'($urandom_range(255)),
                  last: 1'($urandom_range(1))};
      end
    end
  endtask

  // Sends one set of random values; duplicates and extremes are favored.
  task automatic send_set(input int len, input int pct);
    logic [as_pkg::VALUE_BITS-1:0] v;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(9))
        0: v = '0;
        1: v = '1;
        2, 3: v = as_pkg::VALUE_BITS'($urandom_range(3));
        default: v = as_pkg::VALUE_BITS'($urandom_range(255));
      endcase
      send_item(v, i == len - 1);
      idle_gap(pct);
    end
  endtask

  // Random sets, mostly short, some exactly full and some overrunning the store.
  task automatic random_phase(input int pct);
    int goal;
    int r;
    goal = items_sent + ITEMS_PER_PHASE;
    send_set(DEPTH + 2, pct);
    while (items_sent < goal) begin
      r = $urandom_range(99);
      if (r < 8) send_set(DEPTH + $urandom_range(6, 1), pct);
      else if (r < 16) send_set(DEPTH, pct);
      else if (r < 26) send_set(1, pct);
      else send_set($urandom_range(10, 2), pct);
    end
  endtask

  // Stops sending and waits for every outstanding result.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (sort_model.expected_results.size() != 0) @(posedge clk);
  endtask

  initial begin
    sort_model = new(DEPTH);
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed sets: single-element sets at both extremes, mixed extremes,
    // equal values, already-sorted and reverse-sorted input.
    send_item(8'd0, 1'b1);
    send_item(8'd255, 1'b1);
    send_item(8'd255, 1'b0);
    send_item(8'd0, 1'b0);
    send_item(8'd170, 1'b0);
    send_item(8'd85, 1'b1);
    idle_gap(100);
    send_item(8'd7, 1'b0);
    send_item(8'd7, 1'b0);
    send_item(8'd7, 1'b1);
    send_item(8'd1, 1'b0);
    send_item(8'd2, 1'b0);
    send_item(8'd3, 1'b0);
    send_item(8'd4, 1'b1);
    idle_gap(100);
    send_item(8'd200, 1'b0);
    send_item(8'd150, 1'b0);
    send_item(8'd100, 1'b0);
    send_item(8'd50, 1'b1);

    // Sender idles rarely, then often, then never; the pause between phases
    // lets the block empty completely.
    random_phase(6);
    wait_drained();
    random_phase(77);
    wait_drained();
    random_phase(0);
    wait_drained();
    repeat (DEPTH + 8) @(posedge clk);

    if (sort_model.expected_results.size() != 0) begin
      sort_model.mismatches++;
      $display("%0d expected results never arrived", sort_model.expected_results.size());
    end
    $display("Sent %0d items in %0d sets, %0d of which overran the store.",
             items_sent, sort_model.sets_closed, sort_model.overflow_sets);
    $display("Checked %0d sorted results, %0d mismatches.",
             sort_model.results_seen, sort_model.mismatches);
    if (sort_model.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Guards against a hung handshake.
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
src/as_pkg.sv
src/as_cell.sv
src/ascending_sorter.sv
test/tb_ascending_sorter.sv
